// ===== rtl/wsm_pkg.sv =====
`default_nettype none
package wsm_pkg;

	localparam int LENGTH_BITS = 32;

	localparam logic [31:0] LEN_MASK = (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << LENGTH_BITS) - 64'd1);

	localparam logic [31:0] KEY_RESET = 32'hAABB_CCDD;

	localparam logic        REG_MASK_KEY = 1'b0;

	localparam logic        OP_START = 1'b0;
	localparam logic        OP_DATA  = 1'b1;

	localparam logic [7:0]  HDR_FIRST   = 8'h81;
	localparam logic [7:0]  MASK_BIT    = 8'h80;
	localparam logic [6:0]  CODE_LEN16  = 7'd126;
	localparam logic [6:0]  CODE_LEN64  = 7'd127;
	localparam logic [31:0] SHORT_LIMIT = 32'd126;
	localparam logic [31:0] MID_MAX     = 32'd65535;

	localparam logic [1:0]  KIND_HDR  = 2'd0;
	localparam logic [1:0]  KIND_DATA = 2'd1;
	localparam logic [1:0]  KIND_ERR  = 2'd2;

	localparam logic [1:0]  CLS_SHORT = 2'd0;
	localparam logic [1:0]  CLS_MID   = 2'd1;
	localparam logic [1:0]  CLS_LONG  = 2'd2;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  cls;
		logic [31:0] len;
		logic [7:0]  data;
		logic        last;
	} cmd_t;

	function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
		logic [1:0] sel;
		sel = 2'd3 - pos;
		return key[{sel, 3'b000} +: 8];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/wsm_front.sv =====
`default_nettype none
module wsm_front import wsm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        op,
	input  wire logic [31:0] frame_length,
	input  wire logic [7:0]  payload_byte,
	input  wire logic [31:0] key,
	input  wire logic        q_full,
	output logic             push,
	output cmd_t             push_cmd
);

	logic [31:0] bytes_left_q;
	logic [1:0]  key_position_q;
	logic        frame_open_q;

	logic [31:0] len;
	logic        data_end;

	assign push     = in_valid & ~q_full;
	assign len      = frame_length & LEN_MASK;
	assign data_end = (bytes_left_q == 32'd1);

	always_comb begin
		push_cmd      = '0;
		push_cmd.len  = len;
		if (op == OP_DATA) begin
			if (frame_open_q) begin
				push_cmd.kind = KIND_DATA;
				push_cmd.data = payload_byte ^ key_byte(key, key_position_q);
				push_cmd.last = data_end;
			end else begin
				push_cmd.kind = KIND_ERR;
			end
		end else begin
			push_cmd.kind = KIND_HDR;
			push_cmd.last = (len == 32'd0);
			if (len < SHORT_LIMIT) begin
				push_cmd.cls = CLS_SHORT;
			end else if (len <= MID_MAX) begin
				push_cmd.cls = CLS_MID;
			end else begin
				push_cmd.cls = CLS_LONG;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q   <= '0;
			key_position_q <= '0;
			frame_open_q   <= 1'b0;
		end else if (push) begin
			if (op == OP_DATA) begin
				if (frame_open_q) begin
					key_position_q <= key_position_q + 2'd1;
					bytes_left_q   <= bytes_left_q - 32'd1;
					if (data_end) begin
						frame_open_q <= 1'b0;
					end
				end
			end else begin
				key_position_q <= '0;
				bytes_left_q   <= len;
				frame_open_q   <= (len != 32'd0);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/wsm_cmd_queue.sv =====
`default_nettype none
module wsm_cmd_queue import wsm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head_cmd,
	output logic      empty,
	output logic      full
);

	cmd_t                mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]  wr_ptr_q;
	logic [CMDQ_AW-1:0]  rd_ptr_q;
	logic [CMDQ_AW:0]    count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/wsm_back.sv =====
`default_nettype none
module wsm_back import wsm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        head_cmd,
	input  wire logic        q_empty,
	input  wire logic [31:0] key,
	input  wire logic        out_stall,
	output logic             pop,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             frame_end,
	output logic             error
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       frame_end_q;
	logic       error_q;
	logic [3:0] idx_q;

	logic       adv;
	logic       emit;
	logic       hdr_last;
	logic [3:0] n_len;
	logic [3:0] last_idx;
	logic [3:0] rel;
	logic [3:0] len_sel;
	logic [6:0] code;
	logic [63:0] len64;
	logic [7:0] hdr_byte;
	logic [7:0] nxt_byte;
	logic       nxt_end;
	logic       nxt_err;

	assign adv   = ~out_valid_q | ~out_stall;
	assign emit  = ~q_empty & adv;
	assign len64 = {32'd0, head_cmd.len};

	always_comb begin
		case (head_cmd.cls)
			CLS_SHORT: begin
				n_len = 4'd0;
				code  = head_cmd.len[6:0];
			end
			CLS_MID: begin
				n_len = 4'd2;
				code  = CODE_LEN16;
			end
			default: begin
				n_len = 4'd8;
				code  = CODE_LEN64;
			end
		endcase
	end

	assign last_idx = n_len + 4'd5;
	assign hdr_last = (idx_q == last_idx);
	assign rel      = idx_q - 4'd2;
	assign len_sel  = n_len - 4'd1 - rel;

	always_comb begin
		if (idx_q == 4'd0) begin
			hdr_byte = HDR_FIRST;
		end else if (idx_q == 4'd1) begin
			hdr_byte = MASK_BIT | {1'b0, code};
		end else if (rel < n_len) begin
			hdr_byte = len64[{len_sel[2:0], 3'b000} +: 8];
		end else begin
			hdr_byte = key_byte(key, 2'(rel - n_len));
		end
	end

	always_comb begin
		case (head_cmd.kind)
			KIND_HDR: begin
				nxt_byte = hdr_byte;
				nxt_end  = hdr_last & head_cmd.last;
				nxt_err  = 1'b0;
			end
			KIND_DATA: begin
				nxt_byte = head_cmd.data;
				nxt_end  = head_cmd.last;
				nxt_err  = 1'b0;
			end
			default: begin
				nxt_byte = 8'd0;
				nxt_end  = 1'b0;
				nxt_err  = 1'b1;
			end
		endcase
	end

	assign pop = emit & ((head_cmd.kind != KIND_HDR) | hdr_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= emit;
			end
			if (pop) begin
				idx_q <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= nxt_byte;
			frame_end_q <= nxt_end;
			error_q     <= nxt_err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign error     = error_q;

endmodule
`default_nettype wire

// ===== rtl/websocket_client_frame_masker.sv =====
// Masked WebSocket client text frame builder.
// Input channel (in_valid / in_stall): op 0 starts a frame of frame_length
// payload bytes, op 1 carries one payload byte. A transfer completes on a
// clock edge with valid high and stall low.
// Output channel (out_valid / out_stall): one byte per transfer, frame_end on
// the last byte of a frame, error on a payload byte with no open frame.
// A start item yields 6, 8 or 14 header bytes (7-bit, 16-bit or 64-bit length
// form), emitted one per cycle by the output sequencer while out_stall is low.
// A payload or error item yields one byte; these stream at one item per cycle
// while out_stall is low. An item is stored in the command queue, then in the
// output register. A 4-entry command queue separates intake from byte
// emission; in_stall rises only while that queue is full, so a long header or
// a stalled receiver backs up into the input after four pending items. Under
// out_stall the output register holds its byte.
// Mask key register at APB address 0, reset 0xAABBCCDD; write only while idle.
// Reset empties the queue, clears the output valid flag and all frame state.
`default_nettype none
module websocket_client_frame_masker import wsm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [31:0] frame_length,
	input  wire logic [7:0]  payload_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             frame_end,
	output logic             error,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [31:0] mask_key_q;
	logic        q_full;
	logic        q_empty;
	logic        push;
	logic        pop;
	cmd_t        push_cmd;
	cmd_t        head_cmd;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_MASK_KEY) ? mask_key_q : 32'd0;
	assign in_stall = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_key_q <= KEY_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MASK_KEY) begin
			mask_key_q <= pwdata;
		end
	end

	wsm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.op           (op),
		.frame_length (frame_length),
		.payload_byte (payload_byte),
		.key          (mask_key_q),
		.q_full       (q_full),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	wsm_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	wsm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_cmd  (head_cmd),
		.q_empty   (q_empty),
		.key       (mask_key_q),
		.out_stall (out_stall),
		.pop       (pop),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.frame_end (frame_end),
		.error     (error)
	);

endmodule
`default_nettype wire

// ===== rtl/wsm_checker.sv =====
`default_nettype none
module wsm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  out_byte,
	input wire logic        frame_end,
	input wire logic        error,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [2:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(frame_end)
			&& $stable(error))
		else $error("output changed while stalled");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> out_byte == 8'd0 && !frame_end)
		else $error("error result carries data");

	a_key_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && !paddr[2] |=> paddr[2] || prdata == $past(pwdata))
		else $error("mask key readback mismatch");

endmodule

bind websocket_client_frame_masker wsm_checker u_wsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.frame_end (frame_end),
	.error     (error),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);
`default_nettype wire
